>>> rtl/gtsr_pkg.sv
// gtsr_pkg: shared widths, table sizing and word types of the grouped topic score reducer.
// No dependencies; used by every other file of the block by scoped name.
package gtsr_pkg;

  // Table capacity: distinct topics held for one user group
  localparam int MAX_TOPICS = 16;
  localparam int IDX_W      = (MAX_TOPICS > 1) ? $clog2(MAX_TOPICS) : 1;
  localparam int CNT_W      = $clog2(MAX_TOPICS + 1);

  localparam int USER_W  = 32;
  localparam int UP_W    = 64;
  localparam int LO_W    = 56;
  localparam int SCORE_W = 16;
  localparam int SUM_W   = 32;

  // One table entry: topic and its running sum
  typedef struct packed {
    logic [UP_W-1:0]         topic_upper;
    logic [LO_W-1:0]         topic_lower;
    logic signed [SUM_W-1:0] sum;
  } entry_t;

  // Table write request
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } tbl_wr_t;

  // Shared unit result: topic match and next sum
  typedef struct packed {
    logic                    hit;
    logic signed [SUM_W-1:0] sum;
  } alu_res_t;

endpackage

>>> rtl/gtsr_table.sv
// gtsr_table: topic and sum store, one write port, one read port with registered data.
// Depends on gtsr_pkg for entry and write request types.
module gtsr_table (
  input  logic                           clk,
  input  gtsr_pkg::tbl_wr_t              wr,
  input  logic [gtsr_pkg::IDX_W-1:0]     rd_addr,
  output gtsr_pkg::entry_t               rd_data
);

  gtsr_pkg::entry_t mem [gtsr_pkg::MAX_TOPICS];
  gtsr_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/gtsr_alu.sv
// gtsr_alu: shared compare and saturating add, applied to one table entry per cycle.
// Depends on gtsr_pkg for entry and result types.
module gtsr_alu (
  input  gtsr_pkg::entry_t                     entry,
  input  logic                                 entry_ok,
  input  logic [gtsr_pkg::UP_W-1:0]            topic_upper,
  input  logic [gtsr_pkg::LO_W-1:0]            topic_lower,
  input  logic signed [gtsr_pkg::SCORE_W-1:0]  score,
  output gtsr_pkg::alu_res_t                   res
);

  localparam logic signed [gtsr_pkg::SUM_W-1:0] SUM_MAX = {1'b0, {(gtsr_pkg::SUM_W-1){1'b1}}};
  localparam logic signed [gtsr_pkg::SUM_W-1:0] SUM_MIN = {1'b1, {(gtsr_pkg::SUM_W-1){1'b0}}};

  logic                            match;
  logic signed [gtsr_pkg::SUM_W:0] wide;
  logic signed [gtsr_pkg::SUM_W-1:0] score_ext;
  logic signed [gtsr_pkg::SUM_W-1:0] sat;

  always_comb begin
    match     = entry_ok && (entry.topic_upper == topic_upper)
                && (entry.topic_lower == topic_lower);
    score_ext = {{(gtsr_pkg::SUM_W-gtsr_pkg::SCORE_W){score[gtsr_pkg::SCORE_W-1]}}, score};
    wide      = {entry.sum[gtsr_pkg::SUM_W-1], entry.sum}
                + {score_ext[gtsr_pkg::SUM_W-1], score_ext};
    // clamp when the carry and sign bits disagree
    if (wide[gtsr_pkg::SUM_W] != wide[gtsr_pkg::SUM_W-1]) begin
      sat = wide[gtsr_pkg::SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sat = wide[gtsr_pkg::SUM_W-1:0];
    end
    res.hit = match;
    res.sum = match ? sat : score_ext;
  end

endmodule

>>> rtl/grouped_topic_score_reducer_top.sv
// grouped_topic_score_reducer_top: sequencer, group registers and output register.
// Depends on gtsr_pkg, gtsr_table and gtsr_alu.
//
// Usage
//   Records enter on the in_ channel (valid/stall), already grouped by user.
//   A word is taken at a rising edge with in_valid high and in_stall low.
//   Results leave on the out_ channel, one word per table entry of a finished
//   group; out_run_last marks the final word caused by one record.
//   A record for a new user first flushes the open group; a record with
//   in_end_of_stream set is added and its group is then flushed and closed.
// Sequencing
//   in_stall is low only while the sequencer is idle. A record is accepted in
//   the idle state, then table entries are scanned in the search state (1 to
//   MAX_TOPICS, stopping at the first match); each flush emits one word per
//   entry, and an end-of-stream flush first passes the read-turnaround state
//   ST_FPRIME. The table read port is shared by search and flush. Flush words
//   are emitted one per cycle while out_stall is low.
// Reset and stall
//   rst_n (synchronous, active low) closes any group and empties the output
//   register; table contents are left as they are and are never used unwritten.
//   While out_stall is high and a word is held, it holds and the flush waits.
module grouped_topic_score_reducer_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [gtsr_pkg::USER_W-1:0]         in_user_key,
  input  logic [gtsr_pkg::UP_W-1:0]           in_topic_upper,
  input  logic [gtsr_pkg::LO_W-1:0]           in_topic_lower,
  input  logic signed [gtsr_pkg::SCORE_W-1:0] in_score,
  input  logic                                in_end_of_stream,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [gtsr_pkg::USER_W-1:0]         out_user,
  output logic [gtsr_pkg::UP_W-1:0]           out_topic_upper,
  output logic [gtsr_pkg::LO_W-1:0]           out_topic_lower,
  output logic signed [gtsr_pkg::SUM_W-1:0]   out_total,
  output logic                                out_dropped,
  output logic                                out_run_last
);

  localparam int IDX_W = gtsr_pkg::IDX_W;
  localparam int CNT_W = gtsr_pkg::CNT_W;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(gtsr_pkg::MAX_TOPICS);

  // sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_FPRIME = 2'd2;
  localparam logic [1:0] ST_FLUSH  = 2'd3;

  logic [1:0]                          state_r, state_nxt;
  logic [IDX_W-1:0]                    idx_r, idx_nxt;
  logic [CNT_W-1:0]                    count_r, count_nxt;
  logic                                active_r, active_nxt;
  logic                                ovf_r, ovf_nxt;
  logic [gtsr_pkg::USER_W-1:0]         group_user_r, group_user_nxt;
  logic                                eos_phase_r, eos_phase_nxt;

  // latched record
  logic [gtsr_pkg::USER_W-1:0]         user_r, user_nxt;
  logic [gtsr_pkg::UP_W-1:0]           up_r, up_nxt;
  logic [gtsr_pkg::LO_W-1:0]           lo_r, lo_nxt;
  logic signed [gtsr_pkg::SCORE_W-1:0] score_r, score_nxt;
  logic                                eos_r, eos_nxt;

  // output register
  logic                                ov_r, ov_nxt;
  logic [gtsr_pkg::USER_W-1:0]         ou_r, ou_nxt;
  logic [gtsr_pkg::UP_W-1:0]           oup_r, oup_nxt;
  logic [gtsr_pkg::LO_W-1:0]           olo_r, olo_nxt;
  logic signed [gtsr_pkg::SUM_W-1:0]   otot_r, otot_nxt;
  logic                                odrop_r, odrop_nxt;
  logic                                olast_r, olast_nxt;

  gtsr_pkg::tbl_wr_t                   wr;
  gtsr_pkg::entry_t                    rd_data;
  gtsr_pkg::alu_res_t                  alu_res;

  logic                                accept;
  logic                                out_free;
  logic                                scan_last;
  logic                                flush_last;

  gtsr_table u_table (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (idx_nxt),
    .rd_data (rd_data)
  );

  gtsr_alu u_alu (
    .entry       (rd_data),
    .entry_ok    (count_r != '0),
    .topic_upper (up_r),
    .topic_lower (lo_r),
    .score       (score_r),
    .res         (alu_res)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !ov_r || !out_stall;

  assign scan_last  = (CNT_W'(idx_r) + CNT_W'(1)) >= count_r;
  assign flush_last = (CNT_W'(idx_r) + CNT_W'(1)) == count_r;

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    count_nxt      = count_r;
    active_nxt     = active_r;
    ovf_nxt        = ovf_r;
    group_user_nxt = group_user_r;
    eos_phase_nxt  = eos_phase_r;
    user_nxt       = user_r;
    up_nxt         = up_r;
    lo_nxt         = lo_r;
    score_nxt      = score_r;
    eos_nxt        = eos_r;
    ov_nxt         = ov_r && out_stall;
    ou_nxt         = ou_r;
    oup_nxt        = oup_r;
    olo_nxt        = olo_r;
    otot_nxt       = otot_r;
    odrop_nxt      = odrop_r;
    olast_nxt      = olast_r;
    wr             = '0;

    case (state_r)
      ST_IDLE: begin
        idx_nxt = '0;
        if (accept) begin
          user_nxt  = in_user_key;
          up_nxt    = in_topic_upper;
          lo_nxt    = in_topic_lower;
          score_nxt = in_score;
          eos_nxt   = in_end_of_stream;
          if (active_r && (in_user_key != group_user_r)) begin
            // flush the previous user's group first
            eos_phase_nxt = 1'b0;
            state_nxt     = ST_FLUSH;
          end else begin
            if (!active_r) begin
              group_user_nxt = in_user_key;
              count_nxt      = '0;
              ovf_nxt        = 1'b0;
              active_nxt     = 1'b1;
            end
            state_nxt = ST_SEARCH;
          end
        end
      end

      ST_SEARCH: begin
        if (alu_res.hit || scan_last) begin
          if (alu_res.hit) begin
            wr.en   = 1'b1;
            wr.addr = idx_r;
            wr.data = '{topic_upper: up_r, topic_lower: lo_r, sum: alu_res.sum};
          end else if (count_r < CNT_FULL) begin
            wr.en     = 1'b1;
            wr.addr   = count_r[IDX_W-1:0];
            wr.data   = '{topic_upper: up_r, topic_lower: lo_r, sum: alu_res.sum};
            count_nxt = count_r + CNT_W'(1);
          end else begin
            // table full: drop the topic and flag the group
            ovf_nxt = 1'b1;
          end
          idx_nxt = '0;
          if (eos_r) begin
            eos_phase_nxt = 1'b1;
            state_nxt     = ST_FPRIME;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      ST_FPRIME: begin
        // let the last table write settle before reading entry zero
        idx_nxt   = '0;
        state_nxt = ST_FLUSH;
      end

      ST_FLUSH: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          ou_nxt    = group_user_r;
          oup_nxt   = rd_data.topic_upper;
          olo_nxt   = rd_data.topic_lower;
          otot_nxt  = rd_data.sum;
          odrop_nxt = ovf_r;
          olast_nxt = flush_last && (eos_phase_r || !eos_r);
          if (flush_last) begin
            idx_nxt = '0;
            if (eos_phase_r) begin
              active_nxt = 1'b0;
              state_nxt  = ST_IDLE;
            end else begin
              // open the new user's group and add the held record
              group_user_nxt = user_r;
              count_nxt      = '0;
              ovf_nxt        = 1'b0;
              active_nxt     = 1'b1;
              state_nxt      = ST_SEARCH;
            end
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      count_r      <= '0;
      active_r     <= 1'b0;
      ovf_r        <= 1'b0;
      group_user_r <= '0;
      eos_phase_r  <= 1'b0;
      ov_r         <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      count_r      <= count_nxt;
      active_r     <= active_nxt;
      ovf_r        <= ovf_nxt;
      group_user_r <= group_user_nxt;
      eos_phase_r  <= eos_phase_nxt;
      ov_r         <= ov_nxt;
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk) begin
    user_r  <= user_nxt;
    up_r    <= up_nxt;
    lo_r    <= lo_nxt;
    score_r <= score_nxt;
    eos_r   <= eos_nxt;
    ou_r    <= ou_nxt;
    oup_r   <= oup_nxt;
    olo_r   <= olo_nxt;
    otot_r  <= otot_nxt;
    odrop_r <= odrop_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid       = ov_r;
  assign out_user        = ou_r;
  assign out_topic_upper = oup_r;
  assign out_topic_lower = olo_r;
  assign out_total       = otot_r;
  assign out_dropped     = odrop_r;
  assign out_run_last    = olast_r;

endmodule

>>> rtl/gtsr_checker.sv
// gtsr_checker: port-level assertions for the grouped topic score reducer.
// Depends on gtsr_pkg; bound to grouped_topic_score_reducer_top below.
module gtsr_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [gtsr_pkg::USER_W-1:0]         out_user,
  input logic signed [gtsr_pkg::SUM_W-1:0]   out_total,
  input logic                                out_run_last
);

  // output word holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_user) && $stable(out_total)
      && $stable(out_run_last))
    else $error("stalled output word changed");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // a taken record keeps the input stalled while it is worked on
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on consecutive cycles");

  // more words of the same record still to come: input stays stalled
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_run_last |-> in_stall)
    else $error("input ready inside a result run");

endmodule

bind grouped_topic_score_reducer_top gtsr_checker u_gtsr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_user     (out_user),
  .out_total    (out_total),
  .out_run_last (out_run_last)
);

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for grouped_topic_score_reducer_top, with a per-group topic
// sum predictor held in a small scoreboard class. Depends on gtsr_pkg and the block's RTL.
module tb_top;

  localparam int MAX_TOPICS = gtsr_pkg::MAX_TOPICS;
  localparam int USER_W     = gtsr_pkg::USER_W;
  localparam int UP_W       = gtsr_pkg::UP_W;
  localparam int LO_W       = gtsr_pkg::LO_W;
  localparam int SCORE_W    = gtsr_pkg::SCORE_W;
  localparam int SUM_W      = gtsr_pkg::SUM_W;

  // End the run when nothing moves on either channel for this many cycles
  localparam int STUCK_LIMIT = 5000;
  // Records in the random part
  localparam int RANDOM_RECORDS = 240;
  localparam longint SUM_HI = 64'sd2147483647;
  localparam longint SUM_LO = -64'sd2147483648;

  // One result word as it leaves the block
  typedef struct packed {
    logic [USER_W-1:0]       user;
    logic [UP_W-1:0]         topic_upper;
    logic [LO_W-1:0]         topic_lower;
    logic signed [SUM_W-1:0] total;
    logic                    dropped;
    logic                    run_last;
  } flush_word_t;

  // Full 120-bit topic, upper characters first
  typedef struct packed {
    logic [UP_W-1:0] upper;
    logic [LO_W-1:0] lower;
  } topic_t;

  // Per-group topic summing predictor and the queue of words it expects.
  class topic_total_scoreboard;
    flush_word_t             pending_words[$];
    flush_word_t             batch[$];
    int                      failures;
    logic [USER_W-1:0]       open_user;
    bit                      group_open;
    topic_t                  topics[MAX_TOPICS];
    logic signed [SUM_W-1:0] sums[MAX_TOPICS];
    int                      used;
    bit                      lost;

    // Emit every entry of the open group in insertion order, then close it
    function void flush_open_group();
      flush_word_t w;
      for (int k = 0; k < used; k++) begin
        w.user        = open_user;
        w.topic_upper = topics[k].upper;
        w.topic_lower = topics[k].lower;
        w.total       = sums[k];
        w.dropped     = lost;
        w.run_last    = 1'b0;
        batch.push_back(w);
      end
      group_open = 1'b0;
    endfunction

    function void take_record(logic [USER_W-1:0] user, topic_t topic,
                              logic signed [SCORE_W-1:0] score, logic eos);
      flush_word_t w;
      bit          hit;
      longint      t;
      batch.delete();
      if (group_open && user != open_user) flush_open_group();
      if (!group_open) begin
        open_user  = user;
        used       = 0;
        lost       = 1'b0;
        group_open = 1'b1;
      end
      hit = 1'b0;
      for (int k = 0; k < used && !hit; k++) begin
        if (topics[k] == topic) begin
          t = longint'(sums[k]) + longint'(score);
          if (t > SUM_HI) t = SUM_HI;
          else if (t < SUM_LO) t = SUM_LO;
          sums[k] = t[SUM_W-1:0];
          hit = 1'b1;
        end
      end
      if (!hit) begin
        if (used < MAX_TOPICS) begin
          topics[used] = topic;
          sums[used]   = score;
          used++;
        end else begin
          lost = 1'b1;
        end
      end
      if (eos) flush_open_group();
      if (batch.size() > 0) begin
        w = batch.pop_back();
        w.run_last = 1'b1;
        batch.push_back(w);
      end
      foreach (batch[i]) pending_words.push_back(batch[i]);
    endfunction

    function void compare(string field, logic [127:0] want, logic [127:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        failures++;
      end
    endfunction

    function void check_word(flush_word_t got);
      flush_word_t want;
      if (pending_words.size() == 0) begin
        $error("word with no expectation: user %0h total %0d", got.user, got.total);
        failures++;
        return;
      end
      want = pending_words.pop_front();
      compare("out_user", 128'(want.user), 128'(got.user));
      compare("out_topic_upper", 128'(want.topic_upper), 128'(got.topic_upper));
      compare("out_topic_lower", 128'(want.topic_lower), 128'(got.topic_lower));
      compare("out_total", 128'(want.total), 128'(got.total));
      compare("out_dropped", 128'(want.dropped), 128'(got.dropped));
      compare("out_run_last", 128'(want.run_last), 128'(got.run_last));
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic [USER_W-1:0]         in_user_key;
  logic [UP_W-1:0]           in_topic_upper;
  logic [LO_W-1:0]           in_topic_lower;
  logic signed [SCORE_W-1:0] in_score;
  logic                      in_end_of_stream;
  logic                      out_valid;
  logic                      out_stall;
  logic [USER_W-1:0]         out_user;
  logic [UP_W-1:0]           out_topic_upper;
  logic [LO_W-1:0]           out_topic_lower;
  logic signed [SUM_W-1:0]   out_total;
  logic                      out_dropped;
  logic                      out_run_last;

  topic_total_scoreboard board = new();
  int words_seen = 0;
  // Set while both sides are to run without idling
  bit steady = 1'b0;

  grouped_topic_score_reducer_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_user_key      (in_user_key),
    .in_topic_upper   (in_topic_upper),
    .in_topic_lower   (in_topic_lower),
    .in_score         (in_score),
    .in_end_of_stream (in_end_of_stream),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_user         (out_user),
    .out_topic_upper  (out_topic_upper),
    .out_topic_lower  (out_topic_lower),
    .out_total        (out_total),
    .out_dropped      (out_dropped),
    .out_run_last     (out_run_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sender idle length: mostly none or short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [USER_W-1:0] pick_user();
    logic [USER_W-1:0] u;
    if ($urandom_range(0, 1) == 0) return $urandom;
    for (int i = 0; i < 4; i++) u[31-8*i -: 8] = 8'(8'h61 + $urandom_range(0, 25));
    return u;
  endfunction

  // Lower-case text topic of 1 to 15 characters, zero padded
  function automatic topic_t text_topic();
    logic [119:0] t;
    int           n;
    t = '0;
    n = $urandom_range(1, 15);
    for (int i = 0; i < n; i++) t[119-8*i -: 8] = 8'(8'h61 + $urandom_range(0, 25));
    return t;
  endfunction

  function automatic logic signed [SCORE_W-1:0] pick_score();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'sh8000;
    if (r == 1) return 16'sh7FFF;
    return SCORE_W'($urandom);
  endfunction

  // Offer one record, hold it until taken, note it, then idle for a while.
  // Valid is only lowered by the gap, so it is never dropped and raised in one step.
  task automatic send_record(logic [USER_W-1:0] user, topic_t topic,
                             logic signed [SCORE_W-1:0] score, logic eos);
    int n;
    in_valid         <= 1'b1;
    in_user_key      <= user;
    in_topic_upper   <= topic.upper;
    in_topic_lower   <= topic.lower;
    in_score         <= score;
    in_end_of_stream <= eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.take_record(user, topic, score, eos);
    n = gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Pause the sender until every expected word has come out
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending_words.size() != 0) @(posedge clk);
  endtask

  // Check every word taken from the result channel. Sample before the edge's
  // updates land, so stall and valid are the values the block saw.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      words_seen++;
      board.check_word(flush_word_t'({out_user, out_topic_upper, out_topic_lower,
                                      out_total, out_dropped, out_run_last}));
    end
  end

  // Receiver: alternate random stall and flow runs. Once, after enough words,
  // hold off for a long stretch so the flush backs up and the input stalls.
  initial begin : receiver
    bit stalling;
    int left;
    int hold_left;
    bit held;
    stalling  = 1'b0;
    left      = 0;
    hold_left = 0;
    held      = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && words_seen >= 60) begin
        held      = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (steady) begin
        out_stall <= 1'b0;
      end else begin
        if (left == 0) begin
          stalling = !stalling;
          if (stalling)
            left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
          else
            left = $urandom_range(1, 12);
        end
        left--;
        out_stall <= stalling;
      end
    end
  end

  // Watchdog: give up when neither channel has moved for too long
  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
      else stuck++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    topic_t            zero_topic;
    topic_t            full_topic;
    topic_t            tp;
    topic_t            pool[$];
    logic [USER_W-1:0] user;
    logic [USER_W-1:0] prev_user;
    logic [127:0]      bits;
    bit                prev_eos;
    bit                eos;
    int                random_sent;
    int                pool_n;
    int                len;
    int                r;

    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_user_key      <= '0;
    in_topic_upper   <= '0;
    in_topic_lower   <= '0;
    in_score         <= '0;
    in_end_of_stream <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Single-record group closed by end of stream, at the field floors.
    zero_topic = '0;
    full_topic = '1;
    send_record(32'h0, zero_topic, 16'sh8000, 1'b1);
    // Field ceilings; a repeat of the topic adds, a topic differing only in its
    // last padding bit is a separate entry; end of stream flushes both.
    send_record(32'hFFFF_FFFF, full_topic, 16'sh7FFF, 1'b0);
    send_record(32'hFFFF_FFFF, full_topic, 16'sh7FFF, 1'b0);
    send_record(32'hFFFF_FFFF, topic_t'({64'hFFFF_FFFF_FFFF_FFFF, 56'hFF_FFFF_FFFF_FFFE}),
                -16'sd1, 1'b0);
    send_record(32'hFFFF_FFFF, full_topic, 16'sd1, 1'b1);
    // Same user again after end of stream opens a fresh group
    send_record(32'hFFFF_FFFF, topic_t'({"abc", 96'h0}), 16'sd5, 1'b0);
    // User change flushes, then a user change with end of stream flushes twice
    send_record("bob ", topic_t'({"rust", 88'h0}), -16'sd7, 1'b0);
    send_record("carl", topic_t'({"verilog", 64'h0}), 16'sd100, 1'b1);
    // Overfill the table by one topic; the whole group then reports a drop
    for (int k = 0; k <= MAX_TOPICS; k++)
      send_record("dave", topic_t'({64'h746F_7069_635F_0000 | 64'(k), 56'h0}),
                  pick_score(), 1'b0);
    send_record("erin", zero_topic, 16'sd0, 1'b1);
    drain();

    // Random groups: topics drawn from a per-group pool so repeats and near misses
    // are common; a few pools overrun the table.
    random_sent = 0;
    prev_user   = 32'h0;
    prev_eos    = 1'b1;
    user        = 32'h0;
    while (random_sent < RANDOM_RECORDS) begin
      if (prev_eos && $urandom_range(0, 3) == 0) begin
        user = prev_user;
      end else begin
        user = pick_user();
        if (user == prev_user) user ^= 32'h1;
      end
      r = $urandom_range(0, 99);
      pool_n = (r < 70) ? $urandom_range(1, 6) :
               (r < 90) ? $urandom_range(7, MAX_TOPICS) :
                          $urandom_range(MAX_TOPICS + 1, MAX_TOPICS + 6);
      pool.delete();
      for (int k = 0; k < pool_n; k++) begin
        r = $urandom_range(0, 9);
        if (r < 4) begin
          tp = text_topic();
        end else if (r < 7 || pool.size() == 0) begin
          bits = {$urandom, $urandom, $urandom, $urandom};
          tp = bits[119:0];
        end else begin
          tp = pool[$urandom_range(0, pool.size() - 1)] ^ (120'b1 << $urandom_range(0, 119));
        end
        pool.push_back(tp);
      end
      len = pool_n + $urandom_range(0, 6);
      steady = ($urandom_range(0, 5) == 0);
      eos = 1'b0;
      for (int i = 0; i < len; i++) begin
        tp = (i < pool_n) ? pool[i] : pool[$urandom_range(0, pool_n - 1)];
        eos = (i == len - 1) ? ($urandom_range(0, 9) < 4) : ($urandom_range(0, 19) == 0);
        send_record(user, tp, pick_score(), eos);
        random_sent++;
      end
      prev_user = user;
      prev_eos  = eos;
    end
    steady = 1'b0;
    // Close whatever group is still open
    send_record(user, pool[0], pick_score(), 1'b1);
    drain();

    repeat (50) @(posedge clk);
    if (board.failures == 0 && board.pending_words.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
